// ----- design/usq_pkg.sv -----
// ----------------------------------------------------------------------------
// usq_pkg
// Shared types, register indexes and helpers for the uniform scalar quantizer.
// ----------------------------------------------------------------------------
package usq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 8;
  localparam int LBITS_W  = 4;
  localparam int AMP_W    = 15;
  localparam int DIST_W   = 16;
  localparam int CFG_W    = 16;
  localparam int STEP_W   = AMP_W + 2;

  typedef enum logic [1:0] {
    CFG_LEVEL_BITS,
    CFG_MAX_AMP,
    CFG_MIDRISE,
    CFG_REJECT
  } cfg_idx_t;

  localparam logic KIND_QUANT   = 1'b0;
  localparam logic KIND_DEQUANT = 1'b1;

  typedef struct packed {
    logic [LBITS_W-1:0] level_bits;
    logic [AMP_W-1:0]   max_amp;
    logic               midrise;
    logic [DIST_W-1:0]  reject;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_bits: LBITS_W'(3),
    max_amp:    AMP_W'(256),
    midrise:    1'b0,
    reject:     DIST_W'(2560)
  };

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CODE_W-1:0]          code;
  } item_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > 32'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- design/usq_div_pipe.sv -----
// ----------------------------------------------------------------------------
// usq_div_pipe
// Pipelined restoring divider, BPS quotient bits per stage, with payload.
// ----------------------------------------------------------------------------
module usq_div_pipe #(
  parameter int DW  = 17,
  parameter int VW  = 9,
  parameter int BPS = 4,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [PW-1:0] in_payload,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [VW-1:0] out_divisor,
  output logic [PW-1:0] out_payload
);

  localparam int NS = (DW + BPS - 1) / BPS;

  logic          vld_r [1:NS];
  logic [DW-1:0] num_r [1:NS];
  logic [DW-1:0] quo_r [1:NS];
  logic [VW-1:0] rem_r [1:NS];
  logic [VW-1:0] dvs_r [1:NS];
  logic [PW-1:0] pl_r  [1:NS];

  logic [DW-1:0] num_nxt [0:NS-1];
  logic [DW-1:0] quo_nxt [0:NS-1];
  logic [VW-1:0] rem_nxt [0:NS-1];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic          v_src;
    logic [DW-1:0] num_src;
    logic [DW-1:0] quo_src;
    logic [VW-1:0] rem_src;
    logic [VW-1:0] dvs_src;
    logic [PW-1:0] pl_src;

    if (g == 0) begin : g_first
      assign v_src   = in_valid;
      assign num_src = in_dividend;
      assign quo_src = '0;
      assign rem_src = '0;
      assign dvs_src = in_divisor;
      assign pl_src  = in_payload;
    end else begin : g_rest
      assign v_src   = vld_r[g];
      assign num_src = num_r[g];
      assign quo_src = quo_r[g];
      assign rem_src = rem_r[g];
      assign dvs_src = dvs_r[g];
      assign pl_src  = pl_r[g];
    end

    always_comb begin : p_steps
      logic [VW:0]   r;
      logic [DW-1:0] nw;
      logic [DW-1:0] qw;
      logic [VW-1:0] rw;
      logic          qb;
      nw = num_src;
      qw = quo_src;
      rw = rem_src;
      for (int b = 0; b < BPS; b++) begin
        if (g * BPS + b < DW) begin
          r  = {rw, nw[DW-1]};
          nw = nw << 1;
          qb = 1'b0;
          if (r >= {1'b0, dvs_src}) begin
            r  = r - {1'b0, dvs_src};
            qb = 1'b1;
          end
          qw = {qw[DW-2:0], qb};
          rw = r[VW-1:0];
        end
      end
      num_nxt[g] = nw;
      quo_nxt[g] = qw;
      rem_nxt[g] = rw;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g+1] <= num_nxt[g];
        quo_r[g+1] <= quo_nxt[g];
        rem_r[g+1] <= rem_nxt[g];
        dvs_r[g+1] <= dvs_src;
        pl_r[g+1]  <= pl_src;
      end
    end
  end

  assign out_valid   = vld_r[NS];
  assign out_quo     = quo_r[NS];
  assign out_rem     = rem_r[NS];
  assign out_divisor = dvs_r[NS];
  assign out_payload = pl_r[NS];

endmodule

// ----- design/usq_level_pick.sv -----
// ----------------------------------------------------------------------------
// usq_level_pick
// Candidate levels around the quotient, level products, distances and the
// final nearest-level choice with rejection; also serves dequantize.
// ----------------------------------------------------------------------------
module usq_level_pick #(
  parameter int MAX_LEVEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  usq_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  input  usq_pkg::item_t                      in_item,
  input  logic [usq_pkg::STEP_W-1:0]          in_step,
  input  logic [usq_pkg::SAMPLE_W-1:0]        in_quo,
  input  logic [usq_pkg::STEP_W-1:0]          in_rem,
  output logic                                out_valid,
  output logic [usq_pkg::CODE_W-1:0]          out_code,
  output logic signed [usq_pkg::SAMPLE_W-1:0] out_level,
  output logic                                out_error
);
  import usq_pkg::*;

  localparam int EBW = $clog2(MAX_LEVEL_BITS + 1);
  localparam int NW  = MAX_LEVEL_BITS + 1;
  localparam int JW  = MAX_LEVEL_BITS + 1;
  localparam int QW  = SAMPLE_W + 2;
  localparam int MW  = JW + STEP_W + 1;
  localparam int IW  = MAX_LEVEL_BITS;

  logic [EBW-1:0] ebits;
  logic [NW-1:0]  n;
  logic [NW-1:0]  half;
  logic [IW-1:0]  imask;

  assign ebits = (cfg.level_bits > LBITS_W'(MAX_LEVEL_BITS)) ? EBW'(MAX_LEVEL_BITS)
                                                          : EBW'(cfg.level_bits);
  assign n     = NW'(1) << ebits;
  assign half  = n >> 1;
  assign imask = IW'(n - NW'(1));

  function automatic logic signed [JW-1:0] clampj(input logic signed [QW-1:0] v,
                                                  input logic signed [QW-1:0] hs);
    logic signed [QW-1:0] res;
    if (v < -hs) begin
      res = -hs;
    end else if (v > hs - QW'(1)) begin
      res = hs - QW'(1);
    end else begin
      res = v;
    end
    return res[JW-1:0];
  endfunction

  // stage 1: candidate positions
  logic                 v1_r;
  item_t                it1_r;
  logic [STEP_W-1:0]    st1_r;
  logic signed [JW-1:0] cj1_r [3];
  logic                 bad1_r;
  logic signed [JW-1:0] cj1_nxt [3];
  logic                 bad1_nxt;

  always_comb begin
    logic [SAMPLE_W:0]    qmag;
    logic signed [QW-1:0] qs;
    logic signed [QW-1:0] hs;
    logic signed [QW-1:0] jd;
    hs   = $signed(QW'(half));
    qmag = {1'b0, in_quo} + (SAMPLE_W+1)'(in_item.sample[SAMPLE_W-1] && (in_rem != '0));
    if (in_step == '0) begin
      qs = '0;
    end else if (in_item.sample[SAMPLE_W-1]) begin
      qs = -$signed(QW'(qmag));
    end else begin
      qs = $signed(QW'(qmag));
    end
    jd = $signed(QW'(in_item.code));
    if (QW'(in_item.code) >= QW'(half)) begin
      jd = jd - $signed(QW'(n));
    end
    bad1_nxt = QW'(in_item.code) >= QW'(n);
    if (in_item.kind == KIND_DEQUANT) begin
      for (int i = 0; i < 3; i++) begin
        cj1_nxt[i] = jd[JW-1:0];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        cj1_nxt[i] = clampj(qs + QW'(i) - QW'(1), hs);
      end
    end
  end

  // stage 2: level products
  logic                 v2_r;
  item_t                it2_r;
  logic [STEP_W-1:0]    st2_r;
  logic signed [JW-1:0] cj2_r [3];
  logic signed [MW-1:0] prod2_r [3];
  logic [MW-1:0]        mag2_r [3];
  logic                 bad2_r;
  logic signed [MW-1:0] prod2_nxt [3];
  logic [MW-1:0]        mag2_nxt [3];

  always_comb begin
    logic [JW-2:0] k;
    for (int i = 0; i < 3; i++) begin
      prod2_nxt[i] = $signed(cj1_r[i]) * $signed({1'b0, st1_r});
      k = cj1_r[i][JW-1] ? ~cj1_r[i][JW-2:0] : cj1_r[i][JW-2:0];
      mag2_nxt[i] = (MW'({k, 1'b1}) * MW'(st1_r) + MW'(1)) >> 1;
    end
  end

  // stage 3: saturated levels, distances, indexes
  logic                         v3_r;
  item_t                        it3_r;
  logic signed [SAMPLE_W-1:0]   lvl3_r [3];
  logic [SAMPLE_W:0]            dist3_r [3];
  logic [IW-1:0]                idx3_r [3];
  logic                         neg3_r [3];
  logic signed [SAMPLE_W-1:0]   lvl0_3_r;
  logic                         bad3_r;
  logic signed [SAMPLE_W-1:0]   lvl3_nxt [3];
  logic [SAMPLE_W:0]            dist3_nxt [3];
  logic [IW-1:0]                idx3_nxt [3];
  logic signed [SAMPLE_W-1:0]   lvl0_3_nxt;

  always_comb begin
    logic signed [31:0]     raw;
    logic signed [SAMPLE_W:0] df;
    for (int i = 0; i < 3; i++) begin
      if (cfg.midrise) begin
        raw = cj2_r[i][JW-1] ? -$signed(32'(mag2_r[i])) : $signed(32'(mag2_r[i]));
      end else begin
        raw = 32'(prod2_r[i]);
      end
      lvl3_nxt[i]  = sat16(raw);
      df           = (SAMPLE_W+1)'(it2_r.sample) - (SAMPLE_W+1)'(lvl3_nxt[i]);
      dist3_nxt[i] = df[SAMPLE_W] ? (SAMPLE_W+1)'(-df) : (SAMPLE_W+1)'(df);
      idx3_nxt[i]  = IW'(cj2_r[i]) & imask;
    end
    if (cfg.midrise) begin
      lvl0_3_nxt = sat16($signed(32'((STEP_W+1)'(st2_r) + (STEP_W+1)'(1)) >> 1));
    end else begin
      lvl0_3_nxt = '0;
    end
  end

  // stage 4: choice and output register
  logic                       vo_r;
  logic [CODE_W-1:0]          code_r;
  logic signed [SAMPLE_W-1:0] level_r;
  logic                       err_r;
  logic [CODE_W-1:0]          code_nxt;
  logic signed [SAMPLE_W-1:0] level_nxt;
  logic                       err_nxt;

  always_comb begin
    logic [1:0]                 b;
    logic [IW-1:0]              bidx;
    logic signed [SAMPLE_W-1:0] blvl;
    b = 2'd0;
    for (int i = 1; i < 3; i++) begin
      if (dist3_r[i] < dist3_r[b] ||
          (dist3_r[i] == dist3_r[b] && idx3_r[i] < idx3_r[b])) begin
        b = 2'(i);
      end
    end
    bidx = idx3_r[b];
    blvl = lvl3_r[b];
    if (blvl == 16'sh8000 && neg3_r[b]) begin
      bidx = IW'(half);
    end
    if (dist3_r[b] >= (SAMPLE_W+1)'(cfg.reject)) begin
      bidx = '0;
      blvl = lvl0_3_r;
    end
    if (it3_r.kind == KIND_DEQUANT) begin
      code_nxt  = it3_r.code;
      level_nxt = bad3_r ? '0 : lvl3_r[1];
      err_nxt   = bad3_r;
    end else begin
      code_nxt  = CODE_W'(bidx);
      level_nxt = blvl;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r    <= in_item;
      st1_r    <= in_step;
      bad1_r   <= bad1_nxt;
      it2_r    <= it1_r;
      st2_r    <= st1_r;
      bad2_r   <= bad1_r;
      it3_r    <= it2_r;
      bad3_r   <= bad2_r;
      lvl0_3_r <= lvl0_3_nxt;
      code_r   <= code_nxt;
      level_r  <= level_nxt;
      err_r    <= err_nxt;
      for (int i = 0; i < 3; i++) begin
        cj1_r[i]   <= cj1_nxt[i];
        cj2_r[i]   <= cj1_r[i];
        prod2_r[i] <= prod2_nxt[i];
        mag2_r[i]  <= mag2_nxt[i];
        lvl3_r[i]  <= lvl3_nxt[i];
        dist3_r[i] <= dist3_nxt[i];
        idx3_r[i]  <= idx3_nxt[i];
        neg3_r[i]  <= cj2_r[i][JW-1];
      end
    end
  end

  assign out_valid = vo_r;
  assign out_code  = code_r;
  assign out_level = level_r;
  assign out_error = err_r;

endmodule

// ----- design/uniform_scalar_quantizer_core.sv -----
// ----------------------------------------------------------------------------
// uniform_scalar_quantizer_core
// Uniform midtread/midrise quantizer and dequantizer on Q7.8 samples.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_kind, in_sample, in_code_in.
// A quantize transaction returns the nearest level and its code; a dequantize
// transaction returns the level for in_code_in and flags codes out of range.
// Result channel: out_valid/out_stall with out_code_out, out_level,
// out_code_error, one result per input transaction, in order.
// Configuration: cfg_we/cfg_idx/cfg_wdata, written while the block is idle.
// The pipeline has 5 stages of step division (4 quotient bits each),
// 4 stages of sample-by-step division, then candidate, product, distance
// and selection stages. One transaction is taken every cycle unless stalled.
// A stall at the output with a valid result freezes the whole pipeline and
// raises in_stall; nothing is dropped or repeated.
// Reset loads level_bits 3, max_amp 256, midtread, reject_distance 2560, and
// empties the pipeline.
// ----------------------------------------------------------------------------
module uniform_scalar_quantizer_core #(
  parameter int MAX_LEVEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  usq_pkg::cfg_idx_t                   cfg_idx,
  input  logic [usq_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [usq_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [usq_pkg::CODE_W-1:0]          in_code_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [usq_pkg::CODE_W-1:0]          out_code_out,
  output logic signed [usq_pkg::SAMPLE_W-1:0] out_level,
  output logic                                out_code_error
);
  import usq_pkg::*;

  localparam int EBW = $clog2(MAX_LEVEL_BITS + 1);
  localparam int NW  = MAX_LEVEL_BITS + 1;
  localparam int IPW = $bits(item_t);

  typedef struct packed {
    item_t             item;
    logic [STEP_W-1:0] step;
  } item_step_t;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LEVEL_BITS: cfg_r.level_bits <= cfg_wdata[LBITS_W-1:0];
        CFG_MAX_AMP:    cfg_r.max_amp    <= cfg_wdata[AMP_W-1:0];
        CFG_MIDRISE:    cfg_r.midrise    <= cfg_wdata[0];
        CFG_REJECT:     cfg_r.reject     <= cfg_wdata[DIST_W-1:0];
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic [EBW-1:0] ebits;
  logic [NW-1:0]  n;
  logic [NW-1:0]  dvs;
  assign ebits = (cfg_r.level_bits > LBITS_W'(MAX_LEVEL_BITS)) ? EBW'(MAX_LEVEL_BITS)
                                                            : EBW'(cfg_r.level_bits);
  assign n     = NW'(1) << ebits;
  assign dvs   = cfg_r.midrise ? (n - NW'(1)) : n;

  item_t             in_item;
  logic [STEP_W-1:0] step_num;
  assign in_item  = '{kind: in_kind, sample: in_sample, code: in_code_in};
  assign step_num = STEP_W'({cfg_r.max_amp, 1'b0}) + STEP_W'(dvs >> 1);

  logic              d1_valid;
  logic [STEP_W-1:0] d1_quo;
  logic [NW-1:0]     d1_rem;
  logic [NW-1:0]     d1_dvs;
  logic [IPW-1:0]    d1_pl;

  usq_div_pipe #(.DW(STEP_W), .VW(NW), .BPS(4), .PW(IPW)) u_step_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_dividend (step_num),
    .in_divisor  (dvs),
    .in_payload  (in_item),
    .out_valid   (d1_valid),
    .out_quo     (d1_quo),
    .out_rem     (d1_rem),
    .out_divisor (d1_dvs),
    .out_payload (d1_pl)
  );

  item_t             d1_item;
  logic [STEP_W-1:0] step;
  logic [SAMPLE_W-1:0] s_abs;
  item_step_t        d2_in_pl;
  assign d1_item  = item_t'(d1_pl);
  assign step     = (ebits == '0) ? '0 : d1_quo;
  assign s_abs    = d1_item.sample[SAMPLE_W-1] ? SAMPLE_W'(-d1_item.sample)
                                               : SAMPLE_W'(d1_item.sample);
  assign d2_in_pl = '{item: d1_item, step: step};

  logic                 d2_valid;
  logic [SAMPLE_W-1:0]  d2_quo;
  logic [STEP_W-1:0]    d2_rem;
  logic [STEP_W-1:0]    d2_dvs;
  logic [$bits(item_step_t)-1:0] d2_pl;
  item_step_t           d2_out;

  usq_div_pipe #(.DW(SAMPLE_W), .VW(STEP_W), .BPS(4), .PW($bits(item_step_t))) u_samp_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (d1_valid),
    .in_dividend (s_abs),
    .in_divisor  (step),
    .in_payload  (d2_in_pl),
    .out_valid   (d2_valid),
    .out_quo     (d2_quo),
    .out_rem     (d2_rem),
    .out_divisor (d2_dvs),
    .out_payload (d2_pl)
  );

  assign d2_out = item_step_t'(d2_pl);

  usq_level_pick #(.MAX_LEVEL_BITS(MAX_LEVEL_BITS)) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (d2_valid),
    .in_item   (d2_out.item),
    .in_step   (d2_dvs),
    .in_quo    (d2_quo),
    .in_rem    (d2_rem),
    .out_valid (out_valid),
    .out_code  (out_code_out),
    .out_level (out_level),
    .out_error (out_code_error)
  );

  logic unused_d1;
  assign unused_d1 = ^{d1_rem, d1_dvs, d2_out.step};

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_err_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_error |-> out_level == '0)
    else $error("code error with nonzero level");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_error |-> {1'b0, out_code_out} >= (CODE_W+1)'(n))
    else $error("code error flagged for a code in range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Uniform scalar quantizer testbench
// Drives quantize and dequantize transactions through several register
// settings, predicts each result with an independent level search and checks
// results in order, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import usq_pkg::*;

  localparam int MAX_BITS  = 8;
  localparam int LATENCY   = 13;
  localparam int WDOG_MAX  = 20000;

  typedef struct {
    logic [CODE_W-1:0]          code;
    logic signed [SAMPLE_W-1:0] level;
    logic                       err;
  } qres_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_LEVEL_BITS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [CODE_W-1:0] in_code_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODE_W-1:0] out_code_out;
  logic signed [SAMPLE_W-1:0] out_level;
  logic out_code_error;

  uniform_scalar_quantizer_core #(.MAX_LEVEL_BITS(MAX_BITS)) i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [3:0]  q_bits = 4'd3;
  logic [14:0] q_amp = 15'd256;
  logic        q_midrise = 1'b0;
  logic [15:0] q_reject = 16'd2560;
  logic [17:0] q_step;

  qres_t expected_results[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_quant = 0;
  int n_dequant = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic int eff_bits();
    return (q_bits > MAX_BITS) ? MAX_BITS : int'(q_bits);
  endfunction

  function automatic logic [17:0] calc_step();
    int b, n, d;
    b = eff_bits();
    n = 1 << b;
    if (b == 0) return '0;
    d = q_midrise ? n - 1 : n;
    return 18'((2 * int'(q_amp) + d / 2) / d);
  endfunction

  function automatic longint level_at(int i, int n);
    longint st, k, mag;
    bit neg;
    st = longint'(q_step);
    neg = (i >= n / 2);
    if (n <= 1) return 0;
    if (q_midrise) begin
      k = neg ? longint'(n - 1 - i) : longint'(i);
      mag = ((2 * k + 1) * st + 1) / 2;
    end else begin
      mag = neg ? longint'(n - i) * st : longint'(i) * st;
    end
    if (neg) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    return mag;
  endfunction

  function automatic qres_t quantize(logic kind, logic signed [15:0] s, logic [7:0] c);
    qres_t r;
    int n, best;
    longint d, bestd;
    n = 1 << eff_bits();
    if (kind == KIND_DEQUANT) begin
      r.code = c;
      r.err = (int'(c) >= n);
      r.level = r.err ? 16'sd0 : 16'(level_at(int'(c), n));
    end else begin
      best = 0;
      bestd = 0;
      for (int i = 0; i < n; i++) begin
        d = longint'(s) - level_at(i, n);
        if (d < 0) d = -d;
        if (i == 0 || d < bestd) begin
          best = i;
          bestd = d;
        end
      end
      if (bestd >= longint'(q_reject)) best = 0;
      r.code = 8'(best);
      r.level = 16'(level_at(best, n));
      r.err = 1'b0;
    end
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(logic kind, logic signed [15:0] s, logic [7:0] c);
    qres_t r;
    int gap;
    r = quantize(kind, s, c);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample <= s;
    in_code_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(r);
    n_sent++;
    if (kind == KIND_DEQUANT) n_dequant++;
    else n_quant++;
    if (($urandom_range(0, 3) == 0)) begin
      gap = rand_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LEVEL_BITS: q_bits = val[3:0];
      CFG_MAX_AMP:    q_amp = val[14:0];
      CFG_MIDRISE:    q_midrise = val[0];
      CFG_REJECT:     q_reject = val;
      default: ;
    endcase
    q_step = calc_step();
  endtask

  task automatic set_config(int b, int amp, bit mr, int rej);
    drain();
    write_reg(CFG_LEVEL_BITS, 16'(b));
    write_reg(CFG_MAX_AMP, 16'(amp));
    write_reg(CFG_MIDRISE, 16'(mr));
    write_reg(CFG_REJECT, 16'(rej));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] near_level();
    int n;
    n = 1 << eff_bits();
    return 16'(level_at($urandom_range(0, n - 1), n) + $signed($urandom_range(0, 40)) - 20);
  endfunction

  task automatic random_items(int count);
    int p;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 40) send_item(KIND_QUANT, near_level(), 8'($urandom));
      else if (p < 70) send_item(KIND_QUANT, 16'($urandom), 8'($urandom));
      else if (p < 90)
        send_item(KIND_DEQUANT, 16'($urandom), 8'($urandom_range(0, (1 << eff_bits()) - 1)));
      else send_item(KIND_DEQUANT, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_QUANT, 16'sh7FFF, 8'h00);
    send_item(KIND_QUANT, -16'sd32768, 8'hFF);
    send_item(KIND_QUANT, 16'sd0, 8'h00);
    send_item(KIND_QUANT, 16'sd32, 8'h00);
    send_item(KIND_QUANT, -16'sd32, 8'h00);
    send_item(KIND_QUANT, 16'sd100, 8'h00);
    send_item(KIND_DEQUANT, 16'sd0, 8'd0);
    send_item(KIND_DEQUANT, 16'sd0, 8'd7);
    send_item(KIND_DEQUANT, 16'sd0, 8'd4);
    send_item(KIND_DEQUANT, 16'sd0, 8'd8);
    send_item(KIND_DEQUANT, 16'sd0, 8'hFF);
  endtask

  task automatic test_corner_configs();
    set_config(0, 256, 0, 2560);
    send_item(KIND_QUANT, 16'sd500, 8'h00);
    send_item(KIND_DEQUANT, 16'sd0, 8'd1);
    set_config(0, 256, 1, 65535);
    send_item(KIND_QUANT, -16'sd500, 8'h00);
    set_config(15, 32767, 1, 0);
    send_item(KIND_QUANT, 16'sd1234, 8'h00);
    send_item(KIND_DEQUANT, 16'sd0, 8'd128);
    send_item(KIND_DEQUANT, 16'sd0, 8'd127);
    set_config(8, 0, 0, 65535);
    send_item(KIND_QUANT, 16'sh7FFF, 8'h00);
    send_item(KIND_DEQUANT, 16'sd0, 8'd200);
    set_config(1, 32767, 1, 65535);
    send_item(KIND_QUANT, 16'sd0, 8'h00);
    send_item(KIND_DEQUANT, 16'sd0, 8'd1);
    send_item(KIND_DEQUANT, 16'sd0, 8'd2);
  endtask

  task automatic test_random_settings();
    int b;
    for (int ph = 0; ph < 10; ph++) begin
      b = $urandom_range(0, 15);
      set_config(b, (ph % 3 == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 2000),
                 $urandom_range(0, 1),
                 (ph % 4 == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600));
      random_items(100);
    end
  endtask

  task automatic test_backpressure();
    set_config(4, 1000, 0, 65535);
    hold_off = 1'b1;
    random_items(60);
    wait (!hold_off);
  endtask

  initial begin
    q_step = calc_step();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_corner_configs();
    test_backpressure();
    test_random_settings();
    drain();
    $display("Sent %0d transactions (%0d quantize, %0d dequantize), checked %0d results.",
             n_sent, n_quant, n_dequant, n_checked);
    $display("Covered reset defaults, zero bits, oversize bits, zero and full amplitude.");
    if (n_fail == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    int g;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      g = rand_gap();
      out_stall <= (g != 0);
      @(posedge clk);
      repeat (g > 0 ? g - 1 : 0) @(posedge clk);
      if (g > 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    qres_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        n_fail++;
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (out_code_out !== e.code) begin
          $error("code_out: expected %0d, got %0d", e.code, out_code_out);
          n_fail++;
        end
        if (out_level !== e.level) begin
          $error("level: expected %0d, got %0d", e.level, out_level);
          n_fail++;
        end
        if (out_code_error !== e.err) begin
          $error("code_error: expected %0d, got %0d", e.err, out_code_error);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ----- files.f -----
design/usq_pkg.sv
design/usq_div_pipe.sv
design/usq_level_pick.sv
design/uniform_scalar_quantizer_core.sv
tb/testbench.sv
